// ===== sv/utf8_identifier_validator_macros.svh =====
// Assertion helpers for the identifier validator. All assertions are
// clocked on clk_i and are quiet while rst_ni is low.
`ifndef UTF8_IDENTIFIER_VALIDATOR_MACROS_SVH
`define UTF8_IDENTIFIER_VALIDATOR_MACROS_SVH

`ifndef ASSERT_OFF

`define UIV_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("%m: check failed");

`define UIV_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("%m: check failed");

`else

`define UIV_ASSERT(label, prop)

`define UIV_ASSERT_NEXT(label, pre, post)

`endif

`endif

// ===== sv/utf8v_pkg.sv =====
`default_nettype none

package utf8v_pkg;

  localparam int unsigned LENGTH_WIDTH_DEFAULT = 16;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned CFG_INDEX_W = 2;

  // Register indexes of the configuration port.
  localparam logic [CFG_INDEX_W-1:0] CFG_IDENT_MODE  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_ALLOW_EMPTY = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_BYTES   = 2'd2;

  localparam logic [31:0] MAX_BYTES_RESET = 32'd256;

  localparam int unsigned CP_W = 21;
  localparam logic [CP_W-1:0] CP_MAX  = 21'h10FFFF;
  localparam logic [CP_W-1:0] SURR_LO = 21'h00D800;
  localparam logic [CP_W-1:0] SURR_HI = 21'h00DFFF;
  localparam logic [CP_W-1:0] MIN_2B  = 21'h000080;
  localparam logic [CP_W-1:0] MIN_3B  = 21'h000800;
  localparam logic [CP_W-1:0] MIN_4B  = 21'h010000;

  localparam logic [7:0] ASCII_SPACE = 8'h20;
  localparam logic [7:0] ASCII_DEL   = 8'h7F;

  // Per-string decoder state, apart from the length counter.
  typedef struct packed {
    logic            error_seen;
    logic [1:0]      tails_left;
    logic [1:0]      tails_total;
    logic [CP_W-1:0] code_point;
  } utf8v_state_t;

  typedef struct packed {
    logic has_result;
    logic verdict;
  } utf8v_result_t;

endpackage

`default_nettype wire

// ===== sv/utf8v_step.sv =====
`default_nettype none

module utf8v_step #(
  parameter int unsigned LENGTH_WIDTH = utf8v_pkg::LENGTH_WIDTH_DEFAULT
) (
  input  utf8v_pkg::utf8v_state_t  state_i,
  input  logic [LENGTH_WIDTH:0]    count_i,
  input  logic [7:0]               in_byte_i,
  input  logic                     is_last_i,
  input  logic                     is_empty_i,
  input  logic                     ident_mode_i,
  input  logic                     allow_empty_i,
  input  logic [LENGTH_WIDTH-1:0]  max_bytes_i,
  output utf8v_pkg::utf8v_state_t  state_o,
  output logic [LENGTH_WIDTH:0]    count_o,
  output utf8v_pkg::utf8v_result_t result_o
);
  import utf8v_pkg::*;

  localparam int unsigned CNT_W = LENGTH_WIDTH + 1;

  utf8v_state_t     after_byte;
  logic [CNT_W-1:0] count_inc;
  logic [CP_W-1:0]  cp_next;
  logic [CP_W-1:0]  lowest;
  logic             seq_bad;
  logic             too_long;

  assign count_inc = (&count_i) ? count_i : count_i + CNT_W'(1);
  assign cp_next   = {state_i.code_point[CP_W-7:0], in_byte_i[5:0]};
  assign too_long  = ident_mode_i && (count_inc > {1'b0, max_bytes_i});

  always_comb begin
    case (state_i.tails_total)
      2'd1:    lowest = MIN_2B;
      2'd2:    lowest = MIN_3B;
      default: lowest = MIN_4B;
    endcase
  end

  // A finished sequence must be the shortest form and a scalar value.
  assign seq_bad = (cp_next < lowest) || (cp_next > CP_MAX) ||
                   ((cp_next >= SURR_LO) && (cp_next <= SURR_HI));

  always_comb begin
    after_byte = state_i;
    if (state_i.tails_left == 2'd0) begin
      if (!in_byte_i[7]) begin
        if (ident_mode_i && ((in_byte_i < ASCII_SPACE) || (in_byte_i == ASCII_DEL))) begin
          after_byte.error_seen = 1'b1;
        end
      end else if (in_byte_i[7:5] == 3'b110) begin
        after_byte.tails_total = 2'd1;
        after_byte.tails_left  = 2'd1;
        after_byte.code_point  = CP_W'(in_byte_i[4:0]);
      end else if (in_byte_i[7:4] == 4'b1110) begin
        after_byte.tails_total = 2'd2;
        after_byte.tails_left  = 2'd2;
        after_byte.code_point  = CP_W'(in_byte_i[3:0]);
      end else if (in_byte_i[7:3] == 5'b11110) begin
        after_byte.tails_total = 2'd3;
        after_byte.tails_left  = 2'd3;
        after_byte.code_point  = CP_W'(in_byte_i[2:0]);
      end else begin
        after_byte.error_seen = 1'b1;
      end
    end else if (in_byte_i[7:6] != 2'b10) begin
      // The open sequence is dropped and the string stays failed.
      after_byte.error_seen = 1'b1;
      after_byte.tails_left = 2'd0;
    end else begin
      after_byte.code_point = cp_next;
      after_byte.tails_left = state_i.tails_left - 2'd1;
      if ((state_i.tails_left == 2'd1) && seq_bad) begin
        after_byte.error_seen = 1'b1;
      end
    end
  end

  always_comb begin
    state_o             = '0;
    count_o             = '0;
    result_o.has_result = 1'b1;
    if (is_empty_i) begin
      result_o.verdict = ident_mode_i ? 1'b0 : allow_empty_i;
    end else if (is_last_i) begin
      result_o.verdict = !after_byte.error_seen && (after_byte.tails_left == 2'd0) &&
                         !too_long;
    end else begin
      state_o             = after_byte;
      count_o             = count_inc;
      result_o.has_result = 1'b0;
      result_o.verdict    = 1'b0;
    end
  end

endmodule

`default_nettype wire

// ===== sv/utf8v_out_reg.sv =====
`default_nettype none

module utf8v_out_reg (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  logic verdict_i,
  output logic free_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  output logic string_valid_o
);

  logic valid_q;
  logic valid_d;
  logic verdict_q;

  // The slot can be refilled in the same cycle its word is taken.
  assign free_o  = !valid_q || out_ready_i;
  assign valid_d = push_i || (valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      verdict_q <= verdict_i;
    end
  end

  assign out_valid_o    = valid_q;
  assign string_valid_o = verdict_q;

endmodule

`default_nettype wire

// ===== sv/utf8_identifier_validator.sv =====
// Channel   Direction  Handshake                  Payload
// in        input      in_valid_i / in_ready_o    in_byte_i, is_last_i, is_empty_i
// out       output     out_valid_o / out_ready_i  string_valid_o
// cfg       input      cfg_we_i (no wait)         cfg_index_i, cfg_wdata_i
//
// One word is taken every cycle while no verdict word waits in the input register;
// a verdict reaches out_valid_o from the input register via the output register.
// Throughput is set by the single input register feeding one decode step.
// Reset clears the string state and loads identifier_mode 0, allow_empty 1,
// max_bytes 256.
// A verdict word stays in the input register, with in_ready_o low, while the
// output register holds a verdict that is not being taken; other words never wait.
`default_nettype none
`include "utf8_identifier_validator_macros.svh"

module utf8_identifier_validator #(
  parameter int unsigned LENGTH_WIDTH = utf8v_pkg::LENGTH_WIDTH_DEFAULT
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [7:0]                         in_byte_i,
  input  logic                               is_last_i,
  input  logic                               is_empty_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic                               string_valid_o,
  input  logic                               cfg_we_i,
  input  logic [utf8v_pkg::CFG_INDEX_W-1:0]  cfg_index_i,
  input  logic [utf8v_pkg::CFG_DATA_W-1:0]   cfg_wdata_i
);
  import utf8v_pkg::*;

  localparam int unsigned CNT_W = LENGTH_WIDTH + 1;

  logic                    ident_mode_q;
  logic                    allow_empty_q;
  logic [LENGTH_WIDTH-1:0] max_bytes_q;
  logic [31:0]             cfg_wide;

  logic       s1_valid_q;
  logic       s1_valid_d;
  logic [7:0] s1_byte_q;
  logic       s1_last_q;
  logic       s1_empty_q;

  utf8v_state_t     state_q;
  utf8v_state_t     state_d;
  logic [CNT_W-1:0] count_q;
  logic [CNT_W-1:0] count_d;
  utf8v_result_t    result;

  logic in_fire;
  logic s1_fire;
  logic out_free;

  assign cfg_wide = {{(32 - CFG_DATA_W){1'b0}}, cfg_wdata_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ident_mode_q  <= 1'b0;
      allow_empty_q <= 1'b1;
      max_bytes_q   <= MAX_BYTES_RESET[LENGTH_WIDTH-1:0];
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_IDENT_MODE:  ident_mode_q  <= cfg_wdata_i[0];
        CFG_ALLOW_EMPTY: allow_empty_q <= cfg_wdata_i[0];
        CFG_MAX_BYTES:   max_bytes_q   <= cfg_wide[LENGTH_WIDTH-1:0];
        default:         ;
      endcase
    end
  end

  // The decode step retires a word unless it carries a verdict that cannot
  // be parked in the output register yet.
  assign s1_fire    = s1_valid_q && (!result.has_result || out_free);
  assign in_ready_o = !s1_valid_q || s1_fire;
  assign in_fire    = in_valid_i && in_ready_o;
  assign s1_valid_d = in_fire || (s1_valid_q && !s1_fire);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      state_q    <= '0;
      count_q    <= '0;
    end else begin
      s1_valid_q <= s1_valid_d;
      if (s1_fire) begin
        state_q <= state_d;
        count_q <= count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_byte_q  <= in_byte_i;
      s1_last_q  <= is_last_i;
      s1_empty_q <= is_empty_i;
    end
  end

  utf8v_step #(
    .LENGTH_WIDTH (LENGTH_WIDTH)
  ) u_step (
    .state_i       (state_q),
    .count_i       (count_q),
    .in_byte_i     (s1_byte_q),
    .is_last_i     (s1_last_q),
    .is_empty_i    (s1_empty_q),
    .ident_mode_i  (ident_mode_q),
    .allow_empty_i (allow_empty_q),
    .max_bytes_i   (max_bytes_q),
    .state_o       (state_d),
    .count_o       (count_d),
    .result_o      (result)
  );

  utf8v_out_reg u_out_reg (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_i         (s1_fire && result.has_result),
    .verdict_i      (result.verdict),
    .free_o         (out_free),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .string_valid_o (string_valid_o)
  );

  `UIV_ASSERT(a_tails_in_class, state_q.tails_left <= state_q.tails_total)
  `UIV_ASSERT_NEXT(a_clear_on_verdict, s1_fire && result.has_result, count_q == '0 && state_q == '0)
  `UIV_ASSERT_NEXT(a_count_grows, s1_fire && !result.has_result, count_q >= $past(count_q))

endmodule

`default_nettype wire
